// ===== rtl/per_voxel_class_normaliser_defines.svh =====
// Assertion macros shared by the normaliser RTL.
`ifndef PER_VOXEL_CLASS_NORMALISER_DEFINES_SVH
`define PER_VOXEL_CLASS_NORMALISER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PVCN_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PVCN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pvcn_pkg.sv =====
package pvcn_pkg;

    // Number of class lanes; fixed by the one-port-per-class payload.
    localparam int MAX_CLASSES = 4;
    // Width of the class-count register.
    localparam int CNT_W = 3;
    localparam logic [CNT_W-1:0] CNT_RESET = 3'd4;
    // Unsigned Q1.16 result width and one restoring step per result bit.
    localparam int OUT_W = 17;
    localparam int DIV_STEPS = OUT_W;
    // Summing stage followed by the divider steps.
    localparam int NSTG = DIV_STEPS + 1;

    typedef struct packed {
        logic [NSTG-1:0] load;
    } t_pipe_ctrl;

endpackage

// ===== rtl/pvcn_ctrl.sv =====
`include "per_voxel_class_normaliser_defines.svh"

module pvcn_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output pvcn_pkg::t_pipe_ctrl  o_ctrl
);
    import pvcn_pkg::*;

    logic [NSTG-1:0] r_valid;
    logic [NSTG-1:0] n_valid;
    logic [NSTG-1:0] w_load;
    logic            w_in_xfer;
    logic            w_out_xfer;

    // A stage may take new data when it is empty or its content moves on.
    always_comb begin
        w_load[NSTG-1] = !r_valid[NSTG-1] || i_out_ready;
        for (int s = NSTG - 2; s >= 0; s--) begin
            w_load[s] = !r_valid[s] || w_load[s+1];
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (w_load[0]) begin
            n_valid[0] = i_in_valid;
        end
        for (int s = 1; s < NSTG; s++) begin
            if (w_load[s]) begin
                n_valid[s] = r_valid[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_in_ready  = w_load[0];
    assign o_out_valid = r_valid[NSTG-1];
    assign o_ctrl.load = w_load;
    assign w_in_xfer   = i_in_valid && w_load[0];
    assign w_out_xfer  = r_valid[NSTG-1] && i_out_ready;

    `PVCN_ASSERT_NOW(a_full_when_blocked, i_clk, i_rst_n, !w_load[0], &r_valid, "input blocked with a bubble in the pipeline")
    `PVCN_ASSERT_NEXT(a_fill_by_one, i_clk, i_rst_n, w_in_xfer && !w_out_xfer, $countones(r_valid) == $past($countones(r_valid)) + 1, "occupancy did not rise by one")
    `PVCN_ASSERT_NEXT(a_drain_by_one, i_clk, i_rst_n, w_out_xfer && !w_in_xfer, $countones(r_valid) + 1 == $past($countones(r_valid)), "occupancy did not fall by one")

endmodule

// ===== rtl/pvcn_lane.sv =====
module pvcn_lane #(
    parameter int PROB_BITS = 16
) (
    input  logic                                             i_clk,
    input  pvcn_pkg::t_pipe_ctrl                             i_ctrl,
    input  logic [PROB_BITS-1:0]                             i_prob,
    input  logic [PROB_BITS+$clog2(pvcn_pkg::MAX_CLASSES):0] i_sum [pvcn_pkg::NSTG],
    output logic [pvcn_pkg::OUT_W-1:0]                       o_quot
);
    import pvcn_pkg::*;

    // Sum width with one spare bit so that a single class still has room.
    localparam int SUM_W = PROB_BITS + $clog2(MAX_CLASSES) + 1;

    logic [SUM_W-1:0] r_rem [NSTG];
    logic [OUT_W-1:0] r_q   [NSTG];
    logic [SUM_W-1:0] n_rem [NSTG];
    logic [OUT_W-1:0] n_q   [NSTG];

    // One restoring division step per stage. The first step tests the
    // unshifted remainder, giving the integer bit of the quotient.
    always_comb begin
        logic [SUM_W:0] trial;
        logic [SUM_W:0] div;
        logic [SUM_W:0] diff;
        logic           ge;
        n_rem[0] = SUM_W'(i_prob);
        n_q[0]   = '0;
        for (int s = 1; s < NSTG; s++) begin
            if (s == 1) begin
                trial = {1'b0, r_rem[s-1]};
            end else begin
                trial = {r_rem[s-1], 1'b0};
            end
            div      = {1'b0, i_sum[s-1]};
            diff     = trial - div;
            ge       = (trial >= div);
            n_rem[s] = ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
            n_q[s]   = {r_q[s-1][OUT_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NSTG; s++) begin
            if (i_ctrl.load[s]) begin
                r_rem[s] <= n_rem[s];
                r_q[s]   <= n_q[s];
            end
        end
    end

    assign o_quot = r_q[NSTG-1];

endmodule

// ===== rtl/per_voxel_class_normaliser.sv =====
// Per-voxel class normaliser. Each transfer on the input channel carries one
// voxel with up to four unsigned class probabilities; the first class_count of
// them are summed and each is turned into floor(p * 65536 / sum) in unsigned
// Q1.16, so 65536 stands for 1.0, while unused classes give zero. A zero sum
// gives all-zero outputs with o_zero_sum set, and the end-of-volume mark
// travels with its voxel. One voxel is accepted every clock cycle unless all
// stages are full and the result is not taken. The classes are masked and
// summed in the cycle of the transfer and registered with it, then 17 stages
// of a pipelined restoring divider follow, one quotient bit per stage, in
// each of four lanes that share the sum. Each stage holds its item only while
// the stage after it is full, so bubbles close up and the input keeps being
// taken while a finished result waits at the output, until all 18 stages are
// occupied.
// class_count is written through its own channel, which is always ready, and
// must only be changed while no voxel is in flight; 0 is taken as 1 and
// values above four as four.
`include "per_voxel_class_normaliser_defines.svh"

module per_voxel_class_normaliser #(
    parameter int PROB_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Voxel input channel.
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [PROB_BITS-1:0]         i_class_prob_0,
    input  logic [PROB_BITS-1:0]         i_class_prob_1,
    input  logic [PROB_BITS-1:0]         i_class_prob_2,
    input  logic [PROB_BITS-1:0]         i_class_prob_3,
    input  logic                         i_last_voxel,
    // Result channel.
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [pvcn_pkg::OUT_W-1:0]   o_norm_prob_0,
    output logic [pvcn_pkg::OUT_W-1:0]   o_norm_prob_1,
    output logic [pvcn_pkg::OUT_W-1:0]   o_norm_prob_2,
    output logic [pvcn_pkg::OUT_W-1:0]   o_norm_prob_3,
    output logic                         o_zero_sum,
    output logic                         o_last_voxel_out,
    // Configuration write channel.
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [pvcn_pkg::CNT_W-1:0]   i_cfg_data
);
    import pvcn_pkg::*;

    localparam int SUM_W = PROB_BITS + $clog2(MAX_CLASSES) + 1;

    t_pipe_ctrl              w_ctrl;
    logic [CNT_W-1:0]        r_class_count;
    logic [CNT_W-1:0]        w_eff_count;
    logic [PROB_BITS-1:0]    w_prob [MAX_CLASSES];
    logic [PROB_BITS-1:0]    w_used_prob [MAX_CLASSES];
    logic [SUM_W-1:0]        n_sum;
    logic [SUM_W-1:0]        r_sum  [NSTG];
    logic                    r_zero [NSTG];
    logic                    r_last [NSTG];
    logic [OUT_W-1:0]        w_quot [MAX_CLASSES];

    // The configuration channel never stalls; a transfer simply overwrites
    // the class count.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_count <= CNT_RESET;
        end else if (i_cfg_valid) begin
            r_class_count <= i_cfg_data;
        end
    end

    // Clamp the register into the range of lanes actually present.
    always_comb begin
        if (r_class_count == '0) begin
            w_eff_count = CNT_W'(1);
        end else if (r_class_count > CNT_W'(MAX_CLASSES)) begin
            w_eff_count = CNT_W'(MAX_CLASSES);
        end else begin
            w_eff_count = r_class_count;
        end
    end

    assign w_prob[0] = i_class_prob_0;
    assign w_prob[1] = i_class_prob_1;
    assign w_prob[2] = i_class_prob_2;
    assign w_prob[3] = i_class_prob_3;

    // Unused classes are forced to zero before summing, so that they also
    // divide out to zero in their lanes.
    always_comb begin
        n_sum = '0;
        for (int k = 0; k < MAX_CLASSES; k++) begin
            w_used_prob[k] = (CNT_W'(k) < w_eff_count) ? w_prob[k] : '0;
            n_sum          = n_sum + SUM_W'(w_used_prob[k]);
        end
    end

    pvcn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .o_ctrl      (w_ctrl)
    );

    // The divisor, zero flag and end-of-volume mark follow their voxel down
    // the pipeline alongside the lanes.
    always_ff @(posedge i_clk) begin
        if (w_ctrl.load[0]) begin
            r_sum[0]  <= n_sum;
            r_zero[0] <= (n_sum == '0);
            r_last[0] <= i_last_voxel;
        end
        for (int s = 1; s < NSTG; s++) begin
            if (w_ctrl.load[s]) begin
                r_sum[s]  <= r_sum[s-1];
                r_zero[s] <= r_zero[s-1];
                r_last[s] <= r_last[s-1];
            end
        end
    end

    for (genvar k = 0; k < MAX_CLASSES; k++) begin : g_lane
        pvcn_lane #(
            .PROB_BITS (PROB_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_ctrl (w_ctrl),
            .i_prob (w_used_prob[k]),
            .i_sum  (r_sum),
            .o_quot (w_quot[k])
        );
    end

    // With a zero divisor every trial subtraction succeeds, so the lanes'
    // quotients are meaningless there and are masked out.
    assign o_norm_prob_0    = r_zero[NSTG-1] ? '0 : w_quot[0];
    assign o_norm_prob_1    = r_zero[NSTG-1] ? '0 : w_quot[1];
    assign o_norm_prob_2    = r_zero[NSTG-1] ? '0 : w_quot[2];
    assign o_norm_prob_3    = r_zero[NSTG-1] ? '0 : w_quot[3];
    assign o_zero_sum       = r_zero[NSTG-1];
    assign o_last_voxel_out = r_last[NSTG-1];

    // Truncated quotients can never add up to more than one.
    `PVCN_ASSERT_NOW(a_sum_at_most_one, i_clk, i_rst_n, o_valid, (OUT_W + 2)'(o_norm_prob_0) + (OUT_W + 2)'(o_norm_prob_1) + (OUT_W + 2)'(o_norm_prob_2) + (OUT_W + 2)'(o_norm_prob_3) <= (OUT_W + 2)'(65536), "normalised probabilities exceed one")

endmodule

// ===== dv/per_voxel_class_normaliser_tb.sv =====
module per_voxel_class_normaliser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Widths follow the block: 16-bit class probabilities in, Q1.16 out.
    localparam int PROB_W      = 16;
    localparam int N_CLASS     = pvcn_pkg::MAX_CLASSES;
    localparam int OUT_W       = pvcn_pkg::OUT_W;
    localparam int CNT_W       = pvcn_pkg::CNT_W;
    // Settling wait once no result is owed any longer.
    localparam int DRAIN_CYCLES = 24;
    // Far beyond the slowest correct run.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 150;

    typedef logic [N_CLASS-1:0][PROB_W-1:0] prob_vec_t;

    typedef struct packed {
        logic [N_CLASS-1:0][OUT_W-1:0] norm;
        logic                          zero_sum;
        logic                          last_voxel;
    } norm_result_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [PROB_W-1:0] i_class_prob_0;
    logic [PROB_W-1:0] i_class_prob_1;
    logic [PROB_W-1:0] i_class_prob_2;
    logic [PROB_W-1:0] i_class_prob_3;
    logic              i_last_voxel;
    logic              o_valid;
    logic              i_ready;
    logic [OUT_W-1:0]  o_norm_prob_0;
    logic [OUT_W-1:0]  o_norm_prob_1;
    logic [OUT_W-1:0]  o_norm_prob_2;
    logic [OUT_W-1:0]  o_norm_prob_3;
    logic              o_zero_sum;
    logic              o_last_voxel_out;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CNT_W-1:0]  i_cfg_data;

    // Local copy of the class-count register, updated on each configuration transfer.
    logic [CNT_W-1:0]  class_count_shadow;
    // Normalised voxels still owed by the block, oldest first.
    norm_result_t      pending_voxels[$];
    int                mismatch_count;
    int                cycle_count;

    // Idling controls shared by the stimulus and the result-side process.
    bit                sender_idle_en;
    bit                receiver_idle_en;
    bit                hold_request;
    int                hold_left;

    per_voxel_class_normaliser #(
        .PROB_BITS(PROB_W)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_class_prob_0   (i_class_prob_0),
        .i_class_prob_1   (i_class_prob_1),
        .i_class_prob_2   (i_class_prob_2),
        .i_class_prob_3   (i_class_prob_3),
        .i_last_voxel     (i_last_voxel),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_norm_prob_0    (o_norm_prob_0),
        .o_norm_prob_1    (o_norm_prob_1),
        .o_norm_prob_2    (o_norm_prob_2),
        .o_norm_prob_3    (o_norm_prob_3),
        .o_zero_sum       (o_zero_sum),
        .o_last_voxel_out (o_last_voxel_out),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #6 i_clk = ~i_clk;
        end
    end

    // Predicts the normalised voxel. The count is clamped to 1..N_CLASS, classes
    // beyond it are ignored, and each used class becomes floor(p * 65536 / sum),
    // truncated. A zero sum over the used classes gives all zeros and the flag.
    function automatic norm_result_t normalise_voxel(input prob_vec_t probs,
                                                     input logic last_mark,
                                                     input logic [CNT_W-1:0] count);
        int unsigned  used;
        logic [31:0]  class_sum;
        logic [47:0]  scaled;
        norm_result_t res;
        used = count;
        if (used < 1) begin
            used = 1;
        end
        if (used > N_CLASS) begin
            used = N_CLASS;
        end
        class_sum = '0;
        for (int k = 0; k < N_CLASS; k++) begin
            if (k < used) begin
                class_sum = class_sum + 32'(probs[k]);
            end
        end
        for (int k = 0; k < N_CLASS; k++) begin
            if (k < used && class_sum != 0) begin
                scaled = {probs[k], 16'd0};
                res.norm[k] = OUT_W'(scaled / class_sum);
            end else begin
                res.norm[k] = '0;
            end
        end
        res.zero_sum   = (class_sum == 0);
        res.last_voxel = last_mark;
        return res;
    endfunction

    // Random voxel drawn from a mix of shapes, so that zero sums, one-hot
    // voxels, truncation on tiny values and saturated inputs all come up often.
    function automatic prob_vec_t random_voxel();
        prob_vec_t   probs;
        int unsigned shape;
        int unsigned hot;
        shape = $urandom_range(0, 99);
        hot   = $urandom_range(0, N_CLASS - 1);
        for (int k = 0; k < N_CLASS; k++) begin
            if (shape < 40) begin
                probs[k] = PROB_W'($urandom);
            end else if (shape < 55) begin
                probs[k] = PROB_W'($urandom_range(0, 3));
            end else if (shape < 65) begin
                probs[k] = $urandom_range(0, 1) ? '1 : '0;
            end else if (shape < 75) begin
                probs[k] = (k == hot) ? PROB_W'($urandom) : '0;
            end else if (shape < 80) begin
                probs[k] = '0;
            end else if (shape < 90) begin
                probs[k] = PROB_W'(16'hFFFF - $urandom_range(0, 15));
            end else begin
                // Occasional zero in a class keeps partial sums varied.
                probs[k] = $urandom_range(0, 2) == 0 ? '0 : PROB_W'($urandom);
            end
        end
        return probs;
    endfunction

    // Offers one voxel and returns once its transfer has taken place, at the
    // following falling edge. Valid is left high so that back-to-back voxels
    // need no gap; it is lowered only for a random idle or by stop_voxels.
    task automatic send_voxel(input prob_vec_t probs, input logic last_mark);
        int unsigned gap;
        if (sender_idle_en && $urandom_range(0, 99) < 4) begin
            gap = $urandom_range(1, 4);
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid        = 1'b1;
        i_class_prob_0 = probs[0];
        i_class_prob_1 = probs[1];
        i_class_prob_2 = probs[2];
        i_class_prob_3 = probs[3];
        i_last_voxel   = last_mark;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        pending_voxels.insert(pending_voxels.size(),
                              normalise_voxel(probs, last_mark, class_count_shadow));
        @(negedge i_clk);
    endtask

    task automatic send_random_voxels(input int n);
        for (int i = 0; i < n; i++) begin
            send_voxel(random_voxel(), $urandom_range(0, 15) == 0);
        end
    endtask

    // Lowers valid and waits until every owed result has been taken, then
    // lets the pipeline settle before anything else happens.
    task automatic stop_voxels();
        i_valid = 1'b0;
        while (pending_voxels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // The register may only change with nothing in flight, so the stream is
    // drained first.
    task automatic write_class_count(input logic [CNT_W-1:0] value);
        stop_voxels();
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        class_count_shadow = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // With the reset count of four: zero sum, saturated classes, one-hot
    // voxels at both ends of the range, and the end-of-volume mark.
    task automatic test_reset_count();
        send_voxel('{16'd0, 16'd0, 16'd0, 16'd0}, 1'b0);
        send_voxel('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1);
        send_voxel('{16'd0, 16'd0, 16'd0, 16'd1}, 1'b0);
        send_voxel('{16'hFFFF, 16'd0, 16'd0, 16'd0}, 1'b1);
        send_voxel('{16'd1, 16'd1, 16'd1, 16'hFFFF}, 1'b0);
    endtask

    // Each count but the reset four, including out-of-range ones that are clamped,
    // with voxels chosen so that unused classes would change the answer if read.
    task automatic test_count_settings();
        write_class_count(3'd1);
        send_voxel('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0}, 1'b0);
        send_voxel('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1}, 1'b1);
        write_class_count(3'd0);
        send_voxel('{16'd7, 16'd7, 16'd7, 16'd5}, 1'b0);
        send_voxel('{16'd7, 16'd7, 16'd7, 16'd0}, 1'b0);
        write_class_count(3'd7);
        send_voxel('{16'd1, 16'd1, 16'd1, 16'd1}, 1'b1);
        write_class_count(3'd2);
        send_voxel('{16'hFFFF, 16'hFFFF, 16'd2, 16'd1}, 1'b0);
        write_class_count(3'd3);
        send_voxel('{16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0);
        send_voxel('{16'hFFFF, 16'd1, 16'd1, 16'd1}, 1'b0);
        write_class_count(3'd5);
        send_voxel('{16'd3, 16'd2, 16'd1, 16'd0}, 1'b1);
        write_class_count(3'd6);
        send_voxel('{16'h8000, 16'h4000, 16'h0001, 16'h7FFF}, 1'b0);
    endtask

    // Random voxels over a run of count settings; one phase has no idling on
    // either side so that the block runs at its full rate.
    task automatic test_random_voxels();
        logic [CNT_W-1:0] counts[8];
        counts = '{3'd4, 3'd1, 3'd2, 3'd7, 3'd3, 3'd0, 3'd4, 3'd6};
        for (int ph = 0; ph < 8; ph++) begin
            write_class_count(counts[ph]);
            sender_idle_en   = (ph != 3);
            receiver_idle_en = (ph != 3);
            send_random_voxels(ph == 3 ? 150 : 80);
        end
        sender_idle_en   = 1'b1;
        receiver_idle_en = 1'b1;
    endtask

    // The result side holds off for a long stretch while voxels keep coming,
    // so the pipeline fills up and the input channel has to stall.
    task automatic test_result_hold_off();
        write_class_count(3'd4);
        sender_idle_en = 1'b0;
        hold_request   = 1'b1;
        send_random_voxels(60);
        sender_idle_en = 1'b1;
        send_random_voxels(40);
        stop_voxels();
    endtask

    // Result-side ready: random idling, or a counted hold-off on request.
    initial begin
        i_ready   = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_ready   = 1'b0;
            end else begin
                i_ready = !(receiver_idle_en && $urandom_range(0, 99) < 10);
            end
        end
    end

    // Every result transfer is compared with the oldest outstanding prediction.
    always @(posedge i_clk) begin
        norm_result_t want;
        norm_result_t got;
        if (i_rst_n && o_valid && i_ready) begin
            got.norm       = {o_norm_prob_3, o_norm_prob_2, o_norm_prob_1, o_norm_prob_0};
            got.zero_sum   = o_zero_sum;
            got.last_voxel = o_last_voxel_out;
            if (pending_voxels.size() == 0) begin
                $error("result transfer with no voxel outstanding");
                mismatch_count++;
            end else begin
                want = pending_voxels.pop_front();
                for (int k = 0; k < N_CLASS; k++) begin
                    if (got.norm[k] !== want.norm[k]) begin
                        $error("norm_prob_%0d: expected %0d, actual %0d",
                               k, want.norm[k], got.norm[k]);
                        mismatch_count++;
                    end
                end
                if (got.zero_sum !== want.zero_sum) begin
                    $error("zero_sum: expected %0d, actual %0d", want.zero_sum, got.zero_sum);
                    mismatch_count++;
                end
                if (got.last_voxel !== want.last_voxel) begin
                    $error("last_voxel_out: expected %0d, actual %0d",
                           want.last_voxel, got.last_voxel);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        i_valid            = 1'b0;
        i_class_prob_0     = '0;
        i_class_prob_1     = '0;
        i_class_prob_2     = '0;
        i_class_prob_3     = '0;
        i_last_voxel       = 1'b0;
        i_cfg_valid        = 1'b0;
        i_cfg_data         = '0;
        class_count_shadow = pvcn_pkg::CNT_RESET;
        mismatch_count     = 0;
        cycle_count        = 0;
        sender_idle_en     = 1'b1;
        receiver_idle_en   = 1'b1;
        hold_request       = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_count();
        test_count_settings();
        test_random_voxels();
        test_result_hold_off();
        stop_voxels();

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/pvcn_pkg.sv
rtl/pvcn_ctrl.sv
rtl/pvcn_lane.sv
rtl/per_voxel_class_normaliser.sv
dv/per_voxel_class_normaliser_tb.sv
